[hdl/assert_macros.svh]
// assertion macros shared by the gesture classifier rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain clocked property with asynchronous reset disable
`define GBC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication into the following cycle
`define GBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/gbc_pkg.sv]
// types and constants of the button gesture classifier
`default_nettype none

package gbc_pkg;

	localparam int NUM_BUTTONS      = 4;
	localparam int BTN_W            = 2;
	localparam int TICK_COUNT_WIDTH = 16;
	localparam int CFG_DATA_W       = 16;
	localparam int CFG_IDX_W        = 1;

	localparam logic [TICK_COUNT_WIDTH-1:0] WINDOW_RESET = TICK_COUNT_WIDTH'(300);

	// result queue
	localparam int RES_DEPTH = 4;
	localparam int RES_PTR_W = $clog2(RES_DEPTH);
	localparam int RES_CNT_W = RES_PTR_W + 1;

	typedef enum logic [1:0] {
		CMD_CLICK,
		CMD_LP_START,
		CMD_LP_STOP,
		CMD_TICK
	} cmd_t;

	typedef enum logic [1:0] {
		EV_CLICK,
		EV_DOUBLE,
		EV_LP_START,
		EV_LP_STOP
	} ev_t;

	typedef enum logic [1:0] {
		GS_NEUTRAL,
		GS_WAITING,
		GS_LONG
	} gs_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENABLE_MASK,
		REG_WINDOW_TICKS
	} reg_t;

	typedef struct packed {
		ev_t              code;
		logic [BTN_W-1:0] button;
		logic             last;
	} result_t;

	// up to two results written into the queue in the same cycle
	typedef struct packed {
		logic [1:0] cnt;
		result_t    r0;
		result_t    r1;
	} push_t;

endpackage

`default_nettype wire

[hdl/gbc_ifs.sv]
// valid/ready channel interfaces of the button gesture classifier
`default_nettype none

interface gbc_in_if;
	logic                       valid;
	logic                       ready;
	logic [1:0]                 cmd;
	logic [gbc_pkg::BTN_W-1:0]  button;

	modport source (output valid, output cmd, output button, input ready);
	modport sink (input valid, input cmd, input button, output ready);
endinterface

interface gbc_out_if;
	logic                       valid;
	logic                       ready;
	logic [1:0]                 event_code;
	logic [gbc_pkg::BTN_W-1:0]  event_button;
	logic                       last;

	modport source (output valid, output event_code, output event_button, output last,
		input ready);
	modport sink (input valid, input event_code, input event_button, input last,
		output ready);
endinterface

interface gbc_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [gbc_pkg::CFG_IDX_W-1:0]   index;
	logic [gbc_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hdl/gbc_res_fifo.sv]
// result queue: takes up to two results a cycle, hands out one per transaction
`default_nettype none

module gbc_res_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  gbc_pkg::push_t push,
	output logic           room,
	gbc_out_if.source      out
);
	import gbc_pkg::*;

	result_t                res_q [RES_DEPTH];
	logic [RES_PTR_W-1:0]   wr_ptr_q;
	logic [RES_PTR_W-1:0]   rd_ptr_q;
	logic [RES_CNT_W-1:0]   cnt_q;
	logic                   pop;
	result_t                head;

	assign pop  = out.valid && out.ready;
	assign room = cnt_q <= RES_CNT_W'(RES_DEPTH - 2);
	assign head = res_q[rd_ptr_q];

	assign out.valid        = cnt_q != '0;
	assign out.event_code   = head.code;
	assign out.event_button = head.button;
	assign out.last         = head.last;

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			res_q[wr_ptr_q] <= push.r0;
		end
		if (push.cnt == 2'd2) begin
			res_q[wr_ptr_q + RES_PTR_W'(1)] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + RES_PTR_W'(push.cnt);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + RES_PTR_W'(1);
			end
			cnt_q <= cnt_q + RES_CNT_W'(push.cnt) - RES_CNT_W'(pop);
		end
	end

endmodule

`default_nettype wire

[hdl/button_gesture_classifier.sv]
// top level of the button gesture classifier
`default_nettype none
`include "assert_macros.svh"

// Turns raw button events (click, long-press start, long-press stop) and time
// ticks into gesture events: click, double click, long-press start and
// long-press stop, each tagged with its button and a last flag on the final
// result of an input transaction. Each button keeps a gesture state (neutral,
// waiting for a second click, long pressing) in a small synchronous memory; one
// shared window timer measures the double-click window for the button that
// last started it. When an input transaction is accepted the memory read is
// registered into stage 1; the state is updated and the results queued when
// stage 1 moves on, so a new transaction can be taken every cycle while the
// queue has room. A write back that lands on the entry being read is
// forwarded. Results leave through a four-entry queue, one per output
// transaction; input stalls only while the queue has fewer than two free
// entries. There is no clearing pass: per-entry valid bits make every state
// read neutral after reset. enable_mask resets to zero, window_ticks to 300;
// a window of zero behaves as one tick. Configuration writes are always
// accepted.
module button_gesture_classifier (
	input  logic       clk,
	input  logic       arst_n,
	gbc_cfg_if.sink    cfg,
	gbc_in_if.sink     raw,
	gbc_out_if.source  gesture
);
	import gbc_pkg::*;

	// configuration registers
	logic [NUM_BUTTONS-1:0]      enable_q;
	logic [TICK_COUNT_WIDTH-1:0] window_q;

	// gesture state memory and its per-entry valid bits
	gs_t                         gs_mem [NUM_BUTTONS];
	logic [NUM_BUTTONS-1:0]      gs_vld_q;

	// shared window timer
	logic                        running_q;
	logic [BTN_W-1:0]            owner_q;
	logic [TICK_COUNT_WIDTH-1:0] rem_q;
	logic                        running_d;
	logic [BTN_W-1:0]            owner_d;
	logic [TICK_COUNT_WIDTH-1:0] rem_d;
	logic [TICK_COUNT_WIDTH-1:0] rem_dec;

	// stage 1: transaction in flight, memory read data available
	logic                        valid_s1;
	cmd_t                        cmd_s1;
	logic [BTN_W-1:0]            addr_s1;
	gs_t                         gs_rd_s1;
	logic                        fwd_s1;
	gs_t                         fwd_data_s1;

	logic                        raw_fire;
	logic                        s1_fire;
	logic                        room;
	logic [BTN_W-1:0]            rd_addr;
	gs_t                         gs_cur;
	logic                        wr_en;
	gs_t                         wr_data;
	logic                        timer_start;
	logic                        timer_expire;
	push_t                       push;

	// configuration port
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= '0;
			window_q <= WINDOW_RESET;
		end else if (cfg.valid) begin
			case (reg_t'(cfg.index))
				REG_ENABLE_MASK:  enable_q <= cfg.data[NUM_BUTTONS-1:0];
				REG_WINDOW_TICKS: window_q <= cfg.data[TICK_COUNT_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// input handshake: stage 1 moves on whenever the queue can take two results
	assign s1_fire  = valid_s1 && room;
	assign raw.ready = !valid_s1 || room;
	assign raw_fire = raw.valid && raw.ready;

	// a tick reads the timer owner, taking a takeover in stage 1 into account
	assign rd_addr = (cmd_t'(raw.cmd) == CMD_TICK) ? owner_d : raw.button;

	// forwarded write back wins over the stale memory read
	assign gs_cur  = fwd_s1 ? fwd_data_s1 : gs_rd_s1;
	assign rem_dec = (rem_q != '0) ? rem_q - TICK_COUNT_WIDTH'(1) : '0;

	// read-modify-write of one gesture state entry plus the shared timer
	always_comb begin
		wr_en        = 1'b0;
		wr_data      = GS_NEUTRAL;
		timer_start  = 1'b0;
		timer_expire = 1'b0;
		running_d    = running_q;
		owner_d      = owner_q;
		rem_d        = rem_q;
		push         = '0;
		push.r0.button = addr_s1;
		push.r1.button = addr_s1;
		push.r1.code   = EV_LP_START;
		push.r1.last   = 1'b1;
		if (s1_fire) begin
			if (cmd_s1 == CMD_TICK) begin
				if (running_q) begin
					rem_d = rem_dec;
					if (rem_dec == '0) begin
						timer_expire = 1'b1;
						running_d    = 1'b0;
						// owner gets the timeout: a waiting owner gives a click
						if (enable_q[addr_s1] && gs_cur == GS_WAITING) begin
							wr_en        = 1'b1;
							wr_data      = GS_NEUTRAL;
							push.cnt     = 2'd1;
							push.r0.code = EV_CLICK;
						end
					end
				end
			end else if (enable_q[addr_s1]) begin
				case (gs_cur)
					GS_WAITING: begin
						if (cmd_s1 == CMD_CLICK) begin
							running_d    = 1'b0;
							wr_en        = 1'b1;
							wr_data      = GS_NEUTRAL;
							push.cnt     = 2'd1;
							push.r0.code = EV_DOUBLE;
						end else if (cmd_s1 == CMD_LP_START) begin
							// pending click first, then the long press
							running_d    = 1'b0;
							wr_en        = 1'b1;
							wr_data      = GS_LONG;
							push.cnt     = 2'd2;
							push.r0.code = EV_CLICK;
						end
					end
					GS_LONG: begin
						if (cmd_s1 == CMD_LP_STOP) begin
							wr_en        = 1'b1;
							wr_data      = GS_NEUTRAL;
							push.cnt     = 2'd1;
							push.r0.code = EV_LP_STOP;
						end
					end
					default: begin
						// neutral, and the unused code treated the same
						if (cmd_s1 == CMD_CLICK) begin
							// reload and take over the window timer
							timer_start = 1'b1;
							wr_en       = 1'b1;
							wr_data     = GS_WAITING;
							running_d   = 1'b1;
							owner_d     = addr_s1;
							rem_d       = window_q;
						end else if (cmd_s1 == CMD_LP_START) begin
							wr_en        = 1'b1;
							wr_data      = GS_LONG;
							push.cnt     = 2'd1;
							push.r0.code = EV_LP_START;
						end
					end
				endcase
			end
		end
		push.r0.last = (push.cnt == 2'd1);
	end

	// gesture state memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			gs_mem[addr_s1] <= wr_data;
		end
		if (raw_fire) begin
			gs_rd_s1    <= gs_vld_q[rd_addr] ? gs_mem[rd_addr] : GS_NEUTRAL;
			fwd_data_s1 <= wr_data;
			cmd_s1      <= cmd_t'(raw.cmd);
			addr_s1     <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gs_vld_q  <= '0;
			valid_s1  <= 1'b0;
			fwd_s1    <= 1'b0;
			running_q <= 1'b0;
			owner_q   <= '0;
			rem_q     <= '0;
		end else begin
			if (wr_en) begin
				gs_vld_q[addr_s1] <= 1'b1;
			end
			if (raw_fire) begin
				valid_s1 <= 1'b1;
				fwd_s1   <= wr_en && (addr_s1 == rd_addr);
			end else if (s1_fire) begin
				valid_s1 <= 1'b0;
			end
			running_q <= running_d;
			owner_q   <= owner_d;
			rem_q     <= rem_d;
		end
	end

	gbc_res_fifo u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.out    (gesture)
	);

	// two results only come from a long-press start out of waiting
	`GBC_ASSERT(a_two_results_lp, clk, arst_n, (push.cnt != 2'd2) || (cmd_s1 == CMD_LP_START), "two results without long-press start")

	// an expiring window leaves the timer stopped
	`GBC_ASSERT_NEXT(a_expire_stops, clk, arst_n, timer_expire, !running_q, "timer still running after expiry")

	// a click from neutral loads the window and runs the timer
	`GBC_ASSERT_NEXT(a_start_loads, clk, arst_n, timer_start, running_q && (rem_q == $past(window_q)) && (owner_q == $past(addr_s1)), "window timer not loaded on start")

	// results are only queued when the transaction in stage 1 moves on
	`GBC_ASSERT(a_push_fire, clk, arst_n, (push.cnt == 2'd0) || s1_fire, "results queued without stage advance")

endmodule

`default_nettype wire

[sim/button_gesture_classifier_tb.sv]
// self-checking testbench of the button gesture classifier
`default_nettype none

module button_gesture_classifier_tb;
	import gbc_pkg::*;

	localparam int CLK_PERIOD   = 8;
	localparam int RESET_CYCLES = 9;
	localparam int RANDOM_PHASES = 17;
	localparam int PHASE_ITEMS   = 100;
	// cycles left for a transaction that gives no result to clear the block
	localparam int SETTLE_CYCLES = 6;

	typedef struct {
		cmd_t                cmd;
		logic [BTN_W-1:0]    button;
	} raw_event_t;

	typedef struct {
		reg_t                   index;
		logic [CFG_DATA_W-1:0]  data;
	} reg_write_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	gbc_in_if  raw_ch ();
	gbc_out_if gest_ch ();
	gbc_cfg_if cfg_ch ();

	button_gesture_classifier DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_ch),
		.raw     (raw_ch),
		.gesture (gest_ch)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// pending stimulus, register writes and gestures still owed by the block
	raw_event_t raw_events[$];
	reg_write_t reg_writes[$];
	result_t    expected_gestures[$];

	int unsigned fail_count = 0;
	logic        no_idle = 1'b0;

	// mirror of the classifier state
	gs_t                         btn_state [NUM_BUTTONS];
	logic                        win_running;
	logic [BTN_W-1:0]            win_owner;
	logic [TICK_COUNT_WIDTH-1:0] win_left;
	logic [NUM_BUTTONS-1:0]      mask_q;
	logic [TICK_COUNT_WIDTH-1:0] window_q;

	// values chosen for the phase being generated
	logic [NUM_BUTTONS-1:0]      phase_mask;
	logic [TICK_COUNT_WIDTH-1:0] phase_window;
	int unsigned                 phase_count;

	function automatic int unsigned draw_wait();
		if (no_idle)
			return 0;
		return $urandom_range(0, 8);
	endfunction

	function automatic result_t make_gesture(ev_t code, logic [BTN_W-1:0] b);
		result_t r;
		r.code = code;
		r.button = b;
		r.last = 1'b0;
		return r;
	endfunction

	// works out the gestures that one accepted raw event causes
	task automatic classify_event(input cmd_t c, input logic [BTN_W-1:0] b);
		result_t found[$];
		if (c == CMD_TICK) begin
			if (win_running) begin
				if (win_left != '0)
					win_left = win_left - 1'b1;
				// a zero window expires on the first tick
				if (win_left == '0) begin
					win_running = 1'b0;
					// disabled owner or owner no longer waiting: timer just stops
					if (mask_q[win_owner] && btn_state[win_owner] == GS_WAITING) begin
						btn_state[win_owner] = GS_NEUTRAL;
						found.push_back(make_gesture(EV_CLICK, win_owner));
					end
				end
			end
		end else if (mask_q[b]) begin
			case (btn_state[b])
				GS_WAITING: begin
					// either way the shared timer stops, whoever owns it
					if (c == CMD_CLICK) begin
						win_running = 1'b0;
						btn_state[b] = GS_NEUTRAL;
						found.push_back(make_gesture(EV_DOUBLE, b));
					end else if (c == CMD_LP_START) begin
						win_running = 1'b0;
						btn_state[b] = GS_LONG;
						found.push_back(make_gesture(EV_CLICK, b));
						found.push_back(make_gesture(EV_LP_START, b));
					end
				end
				GS_LONG: begin
					if (c == CMD_LP_STOP) begin
						btn_state[b] = GS_NEUTRAL;
						found.push_back(make_gesture(EV_LP_STOP, b));
					end
				end
				default: begin
					// neutral: a click (re)loads the timer and takes it over
					if (c == CMD_CLICK) begin
						btn_state[b] = GS_WAITING;
						win_left = window_q;
						win_running = 1'b1;
						win_owner = b;
					end else if (c == CMD_LP_START) begin
						btn_state[b] = GS_LONG;
						found.push_back(make_gesture(EV_LP_START, b));
					end
				end
			endcase
		end
		if (found.size() != 0)
			found[found.size() - 1].last = 1'b1;
		foreach (found[i])
			expected_gestures.push_back(found[i]);
	endtask

	// raw event driver: one transaction per queued event, random gap after each
	raw_event_t  next_raw;
	int unsigned raw_gap;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_ch.valid <= 1'b0;
			raw_ch.cmd <= CMD_TICK;
			raw_ch.button <= '0;
			raw_gap <= 0;
		end else begin
			if (raw_ch.valid && raw_ch.ready)
				classify_event(cmd_t'(raw_ch.cmd), raw_ch.button);
			if (!raw_ch.valid || raw_ch.ready) begin
				if (raw_gap != 0) begin
					raw_ch.valid <= 1'b0;
					raw_gap <= raw_gap - 1;
				end else if (raw_events.size() != 0) begin
					next_raw = raw_events.pop_front();
					raw_ch.valid <= 1'b1;
					raw_ch.cmd <= next_raw.cmd;
					raw_ch.button <= next_raw.button;
					raw_gap <= draw_wait();
				end else begin
					raw_ch.valid <= 1'b0;
				end
			end
		end
	end

	// register write driver, the mirror takes a value when its transaction completes
	reg_write_t next_reg;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_ch.valid <= 1'b0;
			cfg_ch.index <= REG_ENABLE_MASK;
			cfg_ch.data <= '0;
		end else begin
			if (cfg_ch.valid && cfg_ch.ready) begin
				if (cfg_ch.index == REG_ENABLE_MASK)
					mask_q = cfg_ch.data[NUM_BUTTONS-1:0];
				else
					window_q = cfg_ch.data[TICK_COUNT_WIDTH-1:0];
			end
			if (!cfg_ch.valid || cfg_ch.ready) begin
				if (reg_writes.size() != 0) begin
					next_reg = reg_writes.pop_front();
					cfg_ch.valid <= 1'b1;
					cfg_ch.index <= next_reg.index;
					cfg_ch.data <= next_reg.data;
				end else begin
					cfg_ch.valid <= 1'b0;
				end
			end
		end
	end

	// gesture monitor: random stall before each result, checked against the oldest owed
	result_t     owed;
	int unsigned out_stall;
	int unsigned out_draw;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gest_ch.ready <= 1'b0;
			out_stall <= 0;
		end else begin
			if (gest_ch.valid === 1'b1 && gest_ch.ready) begin
				if (expected_gestures.size() == 0) begin
					$error("gesture with none owed: event_code %0d event_button %0d last %0d",
						gest_ch.event_code, gest_ch.event_button, gest_ch.last);
					fail_count++;
				end else begin
					owed = expected_gestures.pop_front();
					if (gest_ch.event_code !== owed.code) begin
						$error("event_code: expected %0d, actual %0d", owed.code,
							gest_ch.event_code);
						fail_count++;
					end
					if (gest_ch.event_button !== owed.button) begin
						$error("event_button: expected %0d, actual %0d", owed.button,
							gest_ch.event_button);
						fail_count++;
					end
					if (gest_ch.last !== owed.last) begin
						$error("last: expected %0d, actual %0d", owed.last, gest_ch.last);
						fail_count++;
					end
				end
				out_draw = draw_wait();
				out_stall <= out_draw;
				gest_ch.ready <= (out_draw == 0);
			end else if (out_stall != 0) begin
				out_stall <= out_stall - 1;
				gest_ch.ready <= (out_stall == 1);
			end else begin
				gest_ch.ready <= 1'b1;
			end
		end
	end

	task automatic push_event(input cmd_t c, input logic [BTN_W-1:0] b);
		raw_event_t e;
		e.cmd = c;
		e.button = b;
		raw_events.push_back(e);
		phase_count++;
	endtask

	task automatic push_ticks(input int unsigned n);
		repeat (n)
			push_event(CMD_TICK, BTN_W'($urandom_range(0, NUM_BUTTONS - 1)));
	endtask

	task automatic write_reg(input reg_t idx, input logic [CFG_DATA_W-1:0] value);
		reg_write_t w;
		w.index = idx;
		w.data = value;
		reg_writes.push_back(w);
	endtask

	// mid-cycle polling so that queue and valid updates of the edge have settled
	task automatic wait_idle();
		do
			@(negedge clk);
		while (raw_events.size() != 0 || raw_ch.valid || expected_gestures.size() != 0 ||
			reg_writes.size() != 0 || cfg_ch.valid);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [BTN_W-1:0] pick_button();
		logic [BTN_W-1:0] b;
		b = BTN_W'($urandom_range(0, NUM_BUTTONS - 1));
		// mostly enabled buttons so that the gesture machines get exercised
		if (phase_mask != '0 && $urandom_range(0, 4) != 0)
			while (!phase_mask[b])
				b = BTN_W'($urandom_range(0, NUM_BUTTONS - 1));
		return b;
	endfunction

	// one short gesture with random content, or a little noise
	task automatic push_burst();
		logic [BTN_W-1:0] b;
		int unsigned      span;
		b = pick_button();
		span = (phase_window > 6) ? 6 : phase_window;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				// double click, or a window that runs out first
				push_event(CMD_CLICK, b);
				push_ticks($urandom_range(0, span + 1));
				push_event(CMD_CLICK, b);
			end
			4, 5: begin
				push_event(CMD_LP_START, b);
				push_ticks($urandom_range(0, 3));
				push_event(CMD_LP_STOP, b);
			end
			6: begin
				// long press out of the waiting state
				push_event(CMD_CLICK, b);
				push_ticks($urandom_range(0, span));
				push_event(CMD_LP_START, b);
				push_ticks($urandom_range(0, 2));
				push_event(CMD_LP_STOP, b);
			end
			7: begin
				push_ticks($urandom_range(1, span + 2));
			end
			default: begin
				repeat ($urandom_range(1, 3))
					push_event(cmd_t'($urandom_range(0, 3)),
						BTN_W'($urandom_range(0, NUM_BUTTONS - 1)));
			end
		endcase
	endtask

	initial begin
		foreach (btn_state[i])
			btn_state[i] = GS_NEUTRAL;
		win_running = 1'b0;
		win_owner = '0;
		win_left = '0;
		mask_q = '0;
		window_q = WINDOW_RESET;
		phase_count = 0;

		// known levels on every block input before the first edge
		raw_ch.valid = 1'b0;
		raw_ch.cmd = CMD_TICK;
		raw_ch.button = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_ENABLE_MASK;
		cfg_ch.data = '0;
		gest_ch.ready = 1'b0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every button enabled, two-tick window
		write_reg(REG_ENABLE_MASK, 16'h000F);
		write_reg(REG_WINDOW_TICKS, 16'd2);
		wait_idle();
		phase_mask = 4'hF;
		phase_window = 16'd2;
		push_event(CMD_TICK, 2'd0);        // tick with the timer stopped
		push_event(CMD_CLICK, 2'd0);
		push_event(CMD_CLICK, 2'd0);       // double click
		push_event(CMD_CLICK, 2'd1);
		push_ticks(2);                     // window runs out, single click
		push_event(CMD_CLICK, 2'd2);
		push_event(CMD_LP_START, 2'd2);    // click then long-press start
		push_event(CMD_LP_STOP, 2'd2);
		push_event(CMD_LP_START, 2'd3);
		push_event(CMD_CLICK, 2'd3);       // ignored while long pressing
		push_event(CMD_LP_STOP, 2'd3);
		push_event(CMD_LP_STOP, 2'd0);     // stop without a long press, ignored
		push_event(CMD_CLICK, 2'd0);
		push_event(CMD_CLICK, 2'd1);       // takeover, button 0 keeps waiting
		push_ticks(2);
		push_event(CMD_CLICK, 2'd0);
		push_event(CMD_CLICK, 2'd2);
		push_event(CMD_CLICK, 2'd3);
		push_event(CMD_CLICK, 2'd2);       // stops the timer owned by button 3
		push_ticks(2);
		push_event(CMD_CLICK, 2'd3);
		push_event(CMD_CLICK, 2'd0);       // left waiting into the next phase
		wait_idle();

		// directed: button 0 disabled while it owns the timer, zero window
		write_reg(REG_ENABLE_MASK, 16'h000E);
		write_reg(REG_WINDOW_TICKS, 16'd0);
		wait_idle();
		phase_mask = 4'hE;
		phase_window = 16'd0;
		push_ticks(2);                     // expiry for a disabled owner
		push_event(CMD_CLICK, 2'd0);       // disabled, ignored
		push_event(CMD_CLICK, 2'd1);
		push_ticks(1);                     // zero window acts as one tick
		wait_idle();

		// random phases over a spread of settings
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			if (p % 4 == 0)
				phase_mask = 4'hF;
			else if (p == 5)
				phase_mask = 4'h0;
			else
				phase_mask = NUM_BUTTONS'($urandom_range(0, 15));
			if (p == 3)
				phase_window = 16'hFFFF;
			else if (p == 7)
				phase_window = 16'd0;
			else if (p == 11)
				phase_window = 16'd1;
			else
				phase_window = TICK_COUNT_WIDTH'($urandom_range(1, 6));
			no_idle = (p % 5 == 2);
			write_reg(REG_ENABLE_MASK, {12'($urandom_range(0, 4095)), phase_mask});
			write_reg(REG_WINDOW_TICKS, phase_window);
			wait_idle();
			phase_count = 0;
			while (phase_count < PHASE_ITEMS)
				push_burst();
			wait_idle();
		end

		if (fail_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// watchdog far beyond the slowest correct run
	initial begin
		#5000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

`default_nettype wire
